>>> hdl/lpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpm_pkg;

  localparam int GAP_W   = 12;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int MA_W    = 21;
  localparam int MB_W    = 49;
  localparam int P_W     = 64;
  localparam int INT_W   = 40;
  localparam int DER_W   = 39;
  localparam int LOUT_W  = 16;
  localparam int SUM_W   = 18;
  localparam int DRV_W   = 11;
  localparam int GAIN_W  = 48;
  localparam int SLEW_W  = 20;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 32;
  localparam int CFG_IDX_W = 4;

  localparam int NUM_LOOPS = 3;
  localparam int NUM_OUTS  = 5;
  localparam int NUM_GAINS = 6;
  localparam int NUM_COILS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FIRST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LAST  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINTS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW       = 4'd7;

  localparam logic [SLEW_W-1:0] SLEW_RESET = 20'd100000;

  localparam logic signed [MA_W-1:0] K_DERIV = 21'sd1000000;
  localparam logic signed [MA_W-1:0] K_ERR   = 21'sd256000;
  localparam logic signed [MA_W-1:0] K_THOU  = 21'sd1000;
  // ceil(2^39 / 125) and ceil(2^46 / 15625), exact for 32-bit dividends
  localparam logic [32:0] RECIP_125   = 33'd4398046512;
  localparam logic [32:0] RECIP_15625 = 33'd4503599628;
  localparam logic [DVD_W-1:0] ROUND_HALF = 64'd500;
  localparam logic signed [P_W-1:0] ACC_BOUND = 64'sh0000_8000_0000_0000;
  localparam logic signed [SUM_W-1:0] DRIVE_MAX = 18'sd1023;

  localparam logic [1:0] LOOP_MEAN  = 2'd0;
  localparam logic [1:0] LOOP_ROLL  = 2'd1;
  localparam logic [1:0] LOOP_PITCH = 2'd2;

  localparam logic [2:0] OUT_MEAN  = 3'd0;
  localparam logic [2:0] OUT_LEFT  = 3'd1;
  localparam logic [2:0] OUT_RIGHT = 3'd2;
  localparam logic [2:0] OUT_FRONT = 3'd3;
  localparam logic [2:0] OUT_BACK  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_DDIV, ST_DWAIT, ST_EDT, ST_IDIV, ST_IWAIT,
    ST_PE, ST_KI, ST_K1000, ST_KD, ST_ACC, ST_KP, ST_ODIV, ST_OWAIT,
    ST_SLMUL, ST_SLDIV, ST_SLWAIT, ST_RESULT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_DIFF, OP_DIV_DERIV, OP_DZERO, OP_DERIV_FIN,
    OP_MUL_EDT, OP_DIV_INTEG, OP_INTEG_FIN, OP_MUL_PE, OP_MUL_KI, OP_MUL_1KD,
    OP_MUL_KD, OP_ACC_ADD, OP_MUL_KP, OP_DIV_OUT, OP_OUT_FIN, OP_MUL_SLEW,
    OP_DIV_SLEW, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] loop_idx;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic dt_zero;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] lpm_loop_of(input logic [2:0] j);
    logic [1:0] k;
    case (j)
      OUT_MEAN:            k = LOOP_MEAN;
      OUT_LEFT, OUT_RIGHT: k = LOOP_ROLL;
      OUT_FRONT, OUT_BACK: k = LOOP_PITCH;
      default:             k = LOOP_MEAN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lpm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lpm_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [lpm_pkg::DVD_W-1:0] dividend,
  input  logic [lpm_pkg::DVS_W-1:0] divisor,
  output logic                    done,
  output logic [lpm_pkg::DVD_W-1:0] quotient
);
  import lpm_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   sub;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    sub     = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

>>> hdl/lpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lpm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lpm_pkg::sts_t sts,
  output lpm_pkg::cmd_t cmd
);
  import lpm_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [2:0] j_r, j_nxt;
  logic       out_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    out_phase = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          k_nxt     = '0;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op    = OP_MUL_DIFF;
        state_nxt = ST_DDIV;
      end
      ST_DDIV: begin
        if (sts.dt_zero) begin
          cmd.op    = OP_DZERO;
          state_nxt = ST_EDT;
        end else begin
          cmd.op    = OP_DIV_DERIV;
          state_nxt = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_DERIV_FIN;
          state_nxt = ST_EDT;
        end
      end
      ST_EDT: begin
        cmd.op    = OP_MUL_EDT;
        state_nxt = ST_IDIV;
      end
      ST_IDIV: begin
        cmd.op    = OP_DIV_INTEG;
        state_nxt = ST_IWAIT;
      end
      ST_IWAIT: begin
        if (sts.div_done) begin
          cmd.op = OP_INTEG_FIN;
          if (k_r == 2'(NUM_LOOPS - 1)) begin
            j_nxt     = '0;
            state_nxt = ST_PE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_PE: begin
        out_phase = 1'b1;
        cmd.op    = OP_MUL_PE;
        state_nxt = ST_KI;
      end
      ST_KI: begin
        out_phase = 1'b1;
        cmd.op    = OP_MUL_KI;
        state_nxt = ST_K1000;
      end
      ST_K1000: begin
        out_phase = 1'b1;
        cmd.op    = OP_MUL_1KD;
        state_nxt = ST_KD;
      end
      ST_KD: begin
        out_phase = 1'b1;
        cmd.op    = OP_MUL_KD;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        out_phase = 1'b1;
        cmd.op    = OP_ACC_ADD;
        state_nxt = ST_KP;
      end
      ST_KP: begin
        out_phase = 1'b1;
        cmd.op    = OP_MUL_KP;
        state_nxt = ST_ODIV;
      end
      ST_ODIV: begin
        out_phase = 1'b1;
        cmd.op    = OP_DIV_OUT;
        state_nxt = ST_OWAIT;
      end
      ST_OWAIT: begin
        out_phase = 1'b1;
        if (sts.div_done) begin
          cmd.op = OP_OUT_FIN;
          if (j_r == 3'(NUM_OUTS - 1)) begin
            state_nxt = ST_SLMUL;
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = ST_PE;
          end
        end
      end
      ST_SLMUL: begin
        cmd.op    = OP_MUL_SLEW;
        state_nxt = ST_SLDIV;
      end
      ST_SLDIV: begin
        cmd.op    = OP_DIV_SLEW;
        state_nxt = ST_SLWAIT;
      end
      ST_SLWAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.op    = OP_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.loop_idx = out_phase ? lpm_loop_of(j_r) : k_r;
    cmd.out_idx  = j_r;
  end
endmodule
`default_nettype wire

>>> hdl/lpm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lpm_datapath #(
  parameter int DRIVE_CAP      = 255,
  parameter int INTEGRAL_LIMIT = 10000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpm_pkg::cmd_t                     cmd,
  output lpm_pkg::sts_t                     sts,
  input  logic                              cfg_valid,
  input  logic [lpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpm_pkg::GAIN_W-1:0]        cfg_data,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_left,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_right,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_front,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_back,
  input  logic [3:0]                        in_sensor_fault_mask,
  input  logic [15:0]                       in_step_time,
  input  logic                              in_drive_enable,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_front_left,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_back_left,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_front_right,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_back_right,
  output logic                              out_any_fault
);
  import lpm_pkg::*;

  localparam logic signed [INT_W:0]    ILIM = 41'(INTEGRAL_LIMIT) * 41'sd16000;
  localparam logic [LOUT_W-1:0]        CAP  = 16'(DRIVE_CAP);

  logic [GAIN_W-1:0] gain_r [NUM_GAINS];
  logic [GAIN_W-1:0] setp_r;
  logic [SLEW_W-1:0] slew_r;

  logic [GAP_W-1:0] gl_r, gr_r, gf_r, gb_r;
  logic             fault_r;
  logic [15:0]      dt_r;
  logic             en_r;

  logic signed [ERR_W-1:0]  last_err_r [NUM_LOOPS];
  logic signed [INT_W-1:0]  integ_r    [NUM_LOOPS];
  logic signed [DER_W-1:0]  der_r      [NUM_LOOPS];
  logic signed [LOUT_W-1:0] lout_r     [NUM_OUTS];
  logic signed [DRV_W-1:0]  drv_r      [NUM_COILS];
  logic signed [DRV_W-1:0]  drv_nxt    [NUM_COILS];

  logic signed [P_W-1:0] p_r;
  logic signed [P_W-1:0] acc_r;
  logic                  psign_r;
  logic                  out_valid_r;
  logic signed [DRV_W-1:0] o_fl_r, o_bl_r, o_fr_r, o_br_r;
  logic                  o_fault_r;
  logic [25:0]           rq_r;
  logic                  rdone_r;

  logic [13:0]             gsum;
  logic signed [DIFF_W-1:0] e_mean, e_roll, e_pitch, e_sel, diff;
  logic signed [ERR_W-1:0]  e_cur, e_last;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [69:0]       prod;
  logic                     mul_en;
  logic [2:0]               gidx;
  logic                     mirror;
  logic [GAIN_W-1:0]        gword;
  logic signed [15:0]       kp, ki, kd;
  logic signed [MB_W-1:0]   acc_cl;
  logic [DVD_W-1:0]         p_abs;
  logic                     div_start, div_done;
  logic [DVD_W-1:0]         div_dvd, quo;
  logic [DVS_W-1:0]         div_dvs;
  logic                     rdiv_start, rdiv_mega;
  logic [40:0]              out_scaled;
  logic [31:0]              rdv_y;
  logic [32:0]              rdv_m;
  logic [64:0]              rdv_prod;
  logic [25:0]              rq_nxt;
  logic signed [DER_W-1:0]  der_mag, der_val;
  logic signed [INT_W:0]    inc, isum, iclamp;
  logic [LOUT_W-1:0]        omag;
  logic signed [LOUT_W-1:0] oval;
  logic signed [SUM_W-1:0]  tsum   [NUM_COILS];
  logic signed [SUM_W-1:0]  lo_m, lo_l, lo_r, lo_f, lo_b;
  logic signed [DRV_W:0]    tclamp [NUM_COILS];
  logic signed [DRV_W:0]    delta  [NUM_COILS];
  logic [DRV_W-1:0]         dmag   [NUM_COILS];
  logic [16:0]              maxc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_GAINS; i++) gain_r[i] <= '0;
      setp_r <= '0;
      slew_r <= SLEW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index inside {[CFG_GAIN_FIRST:CFG_GAIN_LAST]}) begin
        gain_r[cfg_index[2:0]] <= cfg_data;
      end else if (cfg_index == CFG_SETPOINTS) begin
        setp_r <= cfg_data;
      end else if (cfg_index == CFG_SLEW) begin
        slew_r <= cfg_data[SLEW_W-1:0];
      end
    end
  end

  always_comb begin
    gsum    = 14'(gl_r) + 14'(gr_r) + 14'(gf_r) + 14'(gb_r) + 14'd2;
    e_mean  = $signed({2'b00, setp_r[15:0]}) - $signed({6'b0, gsum[13:2]});
    e_roll  = $signed({6'b0, gr_r}) - $signed({6'b0, gl_r}) - $signed(setp_r[31:16]);
    e_pitch = $signed({6'b0, gb_r}) - $signed({6'b0, gf_r}) - $signed(setp_r[47:32]);
    case (cmd.loop_idx)
      LOOP_MEAN:  e_sel = e_mean;
      LOOP_ROLL:  e_sel = e_roll;
      LOOP_PITCH: e_sel = e_pitch;
      default:    e_sel = e_mean;
    endcase
    e_cur  = e_sel[ERR_W-1:0];
    e_last = last_err_r[cmd.loop_idx];
    diff   = e_sel - DIFF_W'(e_last);

    mirror = (cmd.out_idx == OUT_RIGHT) || (cmd.out_idx == OUT_BACK);
    gidx   = {cmd.loop_idx, 1'b0} + {2'b00, ~(e_last[ERR_W-1] ^ mirror)};
    gword  = gain_r[gidx];
    kp     = $signed(gword[15:0]);
    ki     = $signed(gword[31:16]);
    kd     = $signed(gword[47:32]);

    if (acc_r > ACC_BOUND) begin
      acc_cl = MB_W'(ACC_BOUND);
    end else if (acc_r < -ACC_BOUND) begin
      acc_cl = MB_W'(-ACC_BOUND);
    end else begin
      acc_cl = acc_r[MB_W-1:0];
    end

    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_DIFF: begin
        mul_a = K_DERIV;
        mul_b = MB_W'(diff);
      end
      OP_MUL_EDT: begin
        mul_a = MA_W'(e_cur);
        mul_b = $signed({33'b0, dt_r});
      end
      OP_MUL_PE: begin
        mul_a = K_ERR;
        mul_b = MB_W'(e_last);
      end
      OP_MUL_KI: begin
        mul_a = MA_W'(ki);
        mul_b = MB_W'(integ_r[cmd.loop_idx]);
      end
      OP_MUL_1KD: begin
        mul_a = K_THOU;
        mul_b = MB_W'(der_r[cmd.loop_idx]);
      end
      OP_MUL_KD: begin
        mul_a = MA_W'(kd);
        mul_b = p_r[MB_W-1:0];
      end
      OP_MUL_KP: begin
        mul_a = MA_W'(kp);
        mul_b = acc_cl;
      end
      OP_MUL_SLEW: begin
        mul_a = $signed({5'b0, dt_r});
        mul_b = $signed({29'b0, slew_r});
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
    prod = mul_a * mul_b;

    p_abs     = p_r[P_W-1] ? DVD_W'(-p_r) : DVD_W'(p_r);
    div_start = (cmd.op == OP_DIV_DERIV);
    div_dvd   = p_abs;
    div_dvs   = {16'b0, dt_r};

    // divide by 1000, by 2^20 * 1000 and by 10^6: prescale by a power of two,
    // then multiply by the reciprocal of 125 or 15625
    out_scaled = p_abs[DVD_W-1:23];
    rdiv_start = 1'b1;
    rdiv_mega  = 1'b0;
    rdv_m      = RECIP_125;
    case (cmd.op)
      OP_DIV_INTEG: rdv_y = 32'((p_abs + ROUND_HALF) >> 3);
      OP_DIV_OUT:   rdv_y = (|out_scaled[40:32]) ? '1 : out_scaled[31:0];
      OP_DIV_SLEW: begin
        rdiv_mega = 1'b1;
        rdv_m     = RECIP_15625;
        rdv_y     = 32'(p_abs >> 6);
      end
      default: begin
        rdiv_start = 1'b0;
        rdv_y      = '0;
      end
    endcase
    rdv_prod = rdv_y * rdv_m;
    rq_nxt   = rdiv_mega ? {7'b0, rdv_prod[64:46]} : rdv_prod[64:39];

    der_mag = $signed({1'b0, quo[DER_W-2:0]});
    der_val = psign_r ? -der_mag : der_mag;

    inc  = $signed({15'b0, rq_r});
    inc  = psign_r ? -inc : inc;
    isum = (INT_W+1)'(integ_r[cmd.loop_idx]) + inc;
    if (isum > ILIM) begin
      iclamp = ILIM;
    end else if (isum < -ILIM) begin
      iclamp = -ILIM;
    end else begin
      iclamp = isum;
    end

    omag = (rq_r > 26'(CAP)) ? CAP : rq_r[LOUT_W-1:0];
    oval = $signed(omag);
    if (psign_r ^ mirror) begin
      oval = -oval;
    end

    lo_m = fault_r ? '0 : SUM_W'(lout_r[OUT_MEAN]);
    lo_l = fault_r ? '0 : SUM_W'(lout_r[OUT_LEFT]);
    lo_r = fault_r ? '0 : SUM_W'(lout_r[OUT_RIGHT]);
    lo_f = fault_r ? '0 : SUM_W'(lout_r[OUT_FRONT]);
    lo_b = fault_r ? '0 : SUM_W'(lout_r[OUT_BACK]);
    tsum[0] = lo_m + lo_l + lo_f;
    tsum[1] = lo_m + lo_l + lo_b;
    tsum[2] = lo_m + lo_r + lo_f;
    tsum[3] = lo_m + lo_r + lo_b;
    maxc = rq_r[16:0];
    for (int c = 0; c < NUM_COILS; c++) begin
      if (tsum[c] > DRIVE_MAX) begin
        tclamp[c] = (DRV_W+1)'(DRIVE_MAX);
      end else if (tsum[c] < -DRIVE_MAX) begin
        tclamp[c] = (DRV_W+1)'(-DRIVE_MAX);
      end else begin
        tclamp[c] = tsum[c][DRV_W:0];
      end
      delta[c] = tclamp[c] - (DRV_W+1)'(drv_r[c]);
      dmag[c]  = delta[c][DRV_W] ? DRV_W'(-delta[c]) : DRV_W'(delta[c]);
      if ({6'b0, dmag[c]} > maxc) begin
        if (delta[c][DRV_W]) begin
          drv_nxt[c] = DRV_W'((DRV_W+1)'(drv_r[c]) - $signed({1'b0, maxc[DRV_W-1:0]}));
        end else begin
          drv_nxt[c] = DRV_W'((DRV_W+1)'(drv_r[c]) + $signed({1'b0, maxc[DRV_W-1:0]}));
        end
      end else begin
        drv_nxt[c] = tclamp[c][DRV_W-1:0];
      end
    end
  end

  lpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      gl_r    <= in_gap_left;
      gr_r    <= in_gap_right;
      gf_r    <= in_gap_front;
      gb_r    <= in_gap_back;
      fault_r <= |in_sensor_fault_mask;
      dt_r    <= in_step_time;
      en_r    <= in_drive_enable;
    end
    if (mul_en) begin
      p_r <= prod[P_W-1:0];
    end
    if (div_start || rdiv_start) begin
      psign_r <= p_r[P_W-1];
    end
    if (rdiv_start) begin
      rq_r <= rq_nxt;
    end
    case (cmd.op)
      OP_MUL_KI:  acc_r <= p_r;
      OP_MUL_1KD: acc_r <= acc_r + p_r;
      OP_ACC_ADD: acc_r <= acc_r + p_r;
      OP_DZERO:   der_r[cmd.loop_idx] <= '0;
      OP_DERIV_FIN: der_r[cmd.loop_idx] <= der_val;
      OP_OUT_FIN: lout_r[cmd.out_idx] <= oval;
      default: ;
    endcase
    if (cmd.op == OP_RESULT) begin
      o_fl_r    <= en_r ? drv_nxt[0] : '0;
      o_bl_r    <= en_r ? drv_nxt[1] : '0;
      o_fr_r    <= en_r ? drv_nxt[2] : '0;
      o_br_r    <= en_r ? drv_nxt[3] : '0;
      o_fault_r <= fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LOOPS; i++) begin
        last_err_r[i] <= '0;
        integ_r[i]    <= '0;
      end
      for (int i = 0; i < NUM_COILS; i++) drv_r[i] <= '0;
      out_valid_r <= 1'b0;
      rdone_r     <= 1'b0;
    end else begin
      rdone_r <= rdiv_start;
      if (cmd.op == OP_INTEG_FIN) begin
        integ_r[cmd.loop_idx]    <= iclamp[INT_W-1:0];
        last_err_r[cmd.loop_idx] <= e_cur;
      end
      if (cmd.op == OP_RESULT) begin
        for (int i = 0; i < NUM_COILS; i++) drv_r[i] <= drv_nxt[i];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_done = div_done || rdone_r;
  assign sts.dt_zero  = (dt_r == 16'd0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid             = out_valid_r;
  assign out_drive_front_left  = o_fl_r;
  assign out_drive_back_left   = o_bl_r;
  assign out_drive_front_right = o_fr_r;
  assign out_drive_back_right  = o_br_r;
  assign out_any_fault         = o_fault_r;
endmodule
`default_nettype wire

>>> hdl/levitation_pid_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Four-coil levitation controller: mean, roll and pitch PID loops mixed into
// four slew-limited coil drives. Each loop runs its derivative through the
// shared 64-step divider unless the step time is zero, and every other state
// does one multiply, accumulate or reciprocal-multiply division by a constant
// at a time. The result state also waits while the output register is still
// full. The unit returns to idle in the same cycle as the result is loaded
// and accepts no new transaction before it is back in idle.
// Configuration is accepted every cycle and must only be written while no
// transaction is in flight.
module levitation_pid_mixer_unit #(
  parameter int DRIVE_CAP      = 255,
  parameter int INTEGRAL_LIMIT = 10000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_left,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_right,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_front,
  input  logic [lpm_pkg::GAP_W-1:0]         in_gap_back,
  input  logic [3:0]                        in_sensor_fault_mask,
  input  logic [15:0]                       in_step_time,
  input  logic                              in_drive_enable,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_front_left,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_back_left,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_front_right,
  output logic signed [lpm_pkg::DRV_W-1:0]  out_drive_back_right,
  output logic                              out_any_fault,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpm_pkg::GAIN_W-1:0]        cfg_data
);
  import lpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpm_datapath #(
    .DRIVE_CAP      (DRIVE_CAP),
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_valid             (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_gap_left           (in_gap_left),
    .in_gap_right          (in_gap_right),
    .in_gap_front          (in_gap_front),
    .in_gap_back           (in_gap_back),
    .in_sensor_fault_mask  (in_sensor_fault_mask),
    .in_step_time          (in_step_time),
    .in_drive_enable       (in_drive_enable),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_drive_front_left  (out_drive_front_left),
    .out_drive_back_left   (out_drive_back_left),
    .out_drive_front_right (out_drive_front_right),
    .out_drive_back_right  (out_drive_back_right),
    .out_any_fault         (out_any_fault)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_front_left != 11'sh400) && (out_drive_back_left != 11'sh400) &&
                  (out_drive_front_right != 11'sh400) && (out_drive_back_right != 11'sh400))
    else $error("coil drive outside the clamp range");
`endif
endmodule
`default_nettype wire

>>> test/levitation_pid_mixer_unit_tb.sv
`timescale 1ns / 1ps
module levitation_pid_mixer_unit_tb;
  import lpm_pkg::*;

  localparam int  CAP         = 255;
  localparam int  ILIM        = 10000;
  localparam longint TIMEOUT  = 4000000;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_ATT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_REP  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_ATT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_REP  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_ATT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_REP = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETPTS    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW      = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_TOP       = 4'd15;

  typedef struct packed {
    logic signed [DRV_W-1:0] fl, bl, fr, br;
    logic                    flt;
  } drives_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [GAP_W-1:0] in_gap_left = '0, in_gap_right = '0, in_gap_front = '0, in_gap_back = '0;
  logic [3:0] in_sensor_fault_mask = '0;
  logic [15:0] in_step_time = '0;
  logic in_drive_enable = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic signed [DRV_W-1:0] out_drive_front_left, out_drive_back_left;
  logic signed [DRV_W-1:0] out_drive_front_right, out_drive_back_right;
  logic out_any_fault;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  levitation_pid_mixer_unit #(.DRIVE_CAP(CAP), .INTEGRAL_LIMIT(ILIM)) DUT (.*);

  logic [47:0] gain_word [NUM_GAINS];
  logic [47:0] setpts;
  logic [19:0] slew;
  longint err_hist [NUM_LOOPS];
  longint integ [NUM_LOOPS];
  longint drv_hist [NUM_COILS];
  drives_t pending_drives[$];
  int errors = 0;
  longint cycles = 0;
  bit no_idle = 0;
  bit hold_sink = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("levitation_pid_mixer_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clampl(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint loop_drive(logic [47:0] g, int k, longint der);
    longint s;
    s = 256000 * err_hist[k] + sx16(g[31:16]) * integ[k] + 1000 * sx16(g[47:32]) * der;
    s = clampl(s, longint'(1) << 47);
    return clampl(sx16(g[15:0]) * s / 1048576000, CAP);
  endfunction

  function automatic drives_t coil_drive_predict(logic [11:0] gl, gr, gf, gb,
                                                 logic [3:0] mask, logic [15:0] dt,
                                                 logic en);
    longint e [NUM_LOOPS];
    longint d [NUM_LOOPS];
    longint tgt [NUM_COILS];
    longint m, l, r, f, b, p, inc, maxc, delta, mag;
    drives_t res;
    m = 0; l = 0; r = 0; f = 0; b = 0;
    e[0] = longint'(setpts[15:0]) - ((longint'(gl) + gr + gf + gb + 2) >>> 2);
    e[1] = (longint'(gr) - longint'(gl)) - sx16(setpts[31:16]);
    e[2] = (longint'(gb) - longint'(gf)) - sx16(setpts[47:32]);
    for (int k = 0; k < NUM_LOOPS; k++) begin
      d[k] = (dt != 0) ? (e[k] - err_hist[k]) * 1000000 / longint'(dt) : 0;
      p = e[k] * longint'(dt);
      inc = (p >= 0) ? (p + 500) / 1000 : -((-p + 500) / 1000);
      integ[k] = clampl(integ[k] + inc, longint'(ILIM) * 16000);
      err_hist[k] = e[k];
    end
    if (mask == 0) begin
      m = loop_drive(gain_word[e[0] < 0 ? 0 : 1], 0, d[0]);
      l = loop_drive(gain_word[e[1] < 0 ? 2 : 3], 1, d[1]);
      r = -loop_drive(gain_word[e[1] < 0 ? 3 : 2], 1, d[1]);
      f = loop_drive(gain_word[e[2] < 0 ? 4 : 5], 2, d[2]);
      b = -loop_drive(gain_word[e[2] < 0 ? 5 : 4], 2, d[2]);
    end
    tgt[0] = clampl(m + l + f, 1023);
    tgt[1] = clampl(m + l + b, 1023);
    tgt[2] = clampl(m + r + f, 1023);
    tgt[3] = clampl(m + r + b, 1023);
    maxc = longint'(slew) * longint'(dt) / 1000000;
    for (int k = 0; k < NUM_COILS; k++) begin
      delta = tgt[k] - drv_hist[k];
      mag = delta < 0 ? -delta : delta;
      if (mag > maxc) tgt[k] = drv_hist[k] + (delta > 0 ? maxc : -maxc);
      drv_hist[k] = tgt[k];
      if (!en) tgt[k] = 0;
    end
    res.fl = tgt[0][DRV_W-1:0];
    res.bl = tgt[1][DRV_W-1:0];
    res.fr = tgt[2][DRV_W-1:0];
    res.br = tgt[3][DRV_W-1:0];
    res.flt = (mask != 0);
    return res;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(0, 3);
  endfunction

  // result sink: random backpressure
  initial begin
    forever begin
      @(negedge clk);
      out_ready = hold_sink ? 1'b0 : (no_idle || $urandom_range(0, 3) != 0);
      if (!no_idle && $urandom_range(0, 199) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    drives_t exp_d;
    if (out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction", $time);
      end else begin
        exp_d = pending_drives.pop_front();
        if (out_drive_front_left !== exp_d.fl) begin
          errors++;
          $display("%0t: front_left exp %0d got %0d", $time, exp_d.fl, out_drive_front_left);
        end
        if (out_drive_back_left !== exp_d.bl) begin
          errors++;
          $display("%0t: back_left exp %0d got %0d", $time, exp_d.bl, out_drive_back_left);
        end
        if (out_drive_front_right !== exp_d.fr) begin
          errors++;
          $display("%0t: front_right exp %0d got %0d", $time, exp_d.fr, out_drive_front_right);
        end
        if (out_drive_back_right !== exp_d.br) begin
          errors++;
          $display("%0t: back_right exp %0d got %0d", $time, exp_d.br, out_drive_back_right);
        end
        if (out_any_fault !== exp_d.flt) begin
          errors++;
          $display("%0t: any_fault exp %0b got %0b", $time, exp_d.flt, out_any_fault);
        end
      end
    end
  end

  task automatic send_sample(logic [11:0] gl, gr, gf, gb, logic [3:0] mask,
                             logic [15:0] dt, logic en);
    int gap;
    @(negedge clk);
    in_gap_left = gl; in_gap_right = gr; in_gap_front = gf; in_gap_back = gb;
    in_sensor_fault_mask = mask; in_step_time = dt; in_drive_enable = en;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_drives.push_back(coil_drive_predict(gl, gr, gf, gb, mask, dt, en));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_index = idx; cfg_data = val; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_PITCH_REP) gain_word[idx] = val;
    else if (idx == REG_SETPTS) setpts = val;
    else if (idx == REG_SLEW) slew = val[19:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  task automatic randomize_regs(bit extreme_slew);
    for (int i = 0; i <= REG_PITCH_REP; i++)
      write_reg(i[CFG_IDX_W-1:0], {rand_gain(), rand_gain(), rand_gain()});
    write_reg(REG_SETPTS, {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(1000, 3000))});
    write_reg(REG_SLEW, extreme_slew ? 48'(1000000) : 48'($urandom_range(0, 1000000)));
  endtask

  task automatic test_directed();
    write_reg(REG_MEAN_ATT, {16'h0100, 16'h0010, 16'h0001});
    write_reg(REG_MEAN_REP, {16'h0200, 16'h0020, 16'h7FFF});
    write_reg(REG_ROLL_ATT, {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_ROLL_REP, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(REG_PITCH_ATT, {16'hFF00, 16'h0100, 16'h0400});
    write_reg(REG_PITCH_REP, {16'h0080, 16'hFFF0, 16'h0300});
    write_reg(REG_SETPTS, {16'hFFF0, 16'h0010, 16'd2000});
    write_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_TOP, 48'h1234_5678_9ABC);
    send_sample(12'd2000, 12'd2000, 12'd2000, 12'd2000, 4'h0, 16'd1000, 1'b1);
    send_sample(12'd0, 12'd0, 12'd0, 12'd0, 4'h0, 16'd0, 1'b1);
    send_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 4'h0, 16'hFFFF, 1'b1);
    send_sample(12'd0, 12'hFFF, 12'd0, 12'hFFF, 4'h0, 16'd1, 1'b1);
    send_sample(12'hFFF, 12'd0, 12'hFFF, 12'd0, 4'h0, 16'd1, 1'b1);
    send_sample(12'd1500, 12'd2500, 12'd1800, 12'd2200, 4'h1, 16'd500, 1'b1);
    send_sample(12'd1500, 12'd2500, 12'd1800, 12'd2200, 4'h2, 16'd500, 1'b1);
    send_sample(12'd1500, 12'd2500, 12'd1800, 12'd2200, 4'h4, 16'd500, 1'b1);
    send_sample(12'd1500, 12'd2500, 12'd1800, 12'd2200, 4'h8, 16'd500, 1'b1);
    send_sample(12'd1500, 12'd2500, 12'd1800, 12'd2200, 4'hF, 16'd500, 1'b0);
    send_sample(12'd1000, 12'd3000, 12'd1000, 12'd3000, 4'h0, 16'd2000, 1'b0);
    send_sample(12'd1000, 12'd3000, 12'd1000, 12'd3000, 4'h0, 16'd2000, 1'b1);
    send_sample(12'd1000, 12'd3000, 12'd1000, 12'd3000, 4'h0, 16'd0, 1'b1);
    drain();
    write_reg(REG_SLEW, 48'd0);
    send_sample(12'd100, 12'd4000, 12'd100, 12'd4000, 4'h0, 16'hFFFF, 1'b1);
    drain();
    write_reg(REG_SLEW, 48'hFFFF_FFFF_FFFF);
    send_sample(12'd100, 12'd4000, 12'd4000, 12'd100, 4'h0, 16'hFFFF, 1'b1);
    send_sample(12'd4000, 12'd100, 12'd100, 12'd4000, 4'h0, 16'd10, 1'b1);
    send_sample(12'd2001, 12'd1999, 12'd2003, 12'd1997, 4'h0, 16'd3, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int n, bit extreme_slew);
    logic [15:0] dt;
    logic [11:0] base;
    randomize_regs(extreme_slew);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: dt = 16'($urandom_range(0, 65535));
        1: dt = 16'($urandom_range(0, 3));
        default: dt = 16'($urandom_range(100, 5000));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        send_sample(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                    4'($urandom), dt, 1'($urandom));
      end else begin
        base = 12'(setpts[15:0] > 16'd4000 ? 16'd2000 : setpts[15:0]);
        send_sample(12'(base + $urandom_range(0, 80) - 40), 12'(base + $urandom_range(0, 80) - 40),
                    12'(base + $urandom_range(0, 80) - 40), 12'(base + $urandom_range(0, 80) - 40),
                    ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0, dt,
                    $urandom_range(0, 7) != 0);
      end
      if (i == n / 2) drain();
    end
    no_idle = 0;
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_GAINS; i++) gain_word[i] = '0;
    setpts = '0;
    slew = SLEW_RESET;
    for (int i = 0; i < NUM_LOOPS; i++) begin
      err_hist[i] = 0;
      integ[i] = 0;
    end
    for (int i = 0; i < NUM_COILS; i++) drv_hist[i] = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    hold_sink = 1'b0;
    send_sample(12'd10, 12'd20, 12'd30, 12'd40, 4'h0, 16'd100, 1'b1);
    drain();
    test_directed();
    test_random_phase(145, 1'b1);
    test_random_phase(145, 1'b0);
    test_random_phase(145, 1'b0);
    test_random_phase(145, 1'b1);
    drain();
    repeat (1000) @(posedge clk);
    if (errors == 0 && pending_drives.size() == 0)
      $display("levitation_pid_mixer_unit_tb: PASS");
    else
      $display("levitation_pid_mixer_unit_tb: FAIL");
    $finish;
  end

endmodule
